// File: design/learning_message_forwarder_assert.svh
// Assertion macros for the learning message forwarder.
// Used by the top level; expects signals clk and rst_n in the including scope.
`ifndef LEARNING_MESSAGE_FORWARDER_ASSERT_SVH
`define LEARNING_MESSAGE_FORWARDER_ASSERT_SVH

// Same-cycle implication, gated off during reset.
`define LMF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated off during reset.
`define LMF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/lmf_pkg.sv
// Shared types and constants of the learning message forwarder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lmf_pkg;

    localparam int NUM_PORTS_DEF   = 8;
    localparam int NUM_DEVICES_DEF = 256;

    localparam int FUNC_W       = 3;
    localparam int ID_W         = 8;
    localparam int PORT_FIELD_W = 4;
    localparam int MASK_W       = 8;
    localparam int KIND_W       = 2;
    localparam int DPORT_W      = 3;

    localparam logic [ID_W-1:0] BROADCAST_ID = 8'd255;

    // depth of the command queue and the result queue
    localparam int Q_DEPTH = 2;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_PACKET,
        OP_SET,
        OP_MARK,
        OP_CLEAR,
        OP_INVAL
    } op_t;

    typedef struct packed {
        op_t                     op;
        logic                    ext;
        logic [PORT_FIELD_W-1:0] port;
        logic [ID_W-1:0]         sender_id;
        logic [ID_W-1:0]         receiver_id;
        logic [ID_W-1:0]         table_device_id;
    } cmd_t;

    typedef struct packed {
        logic [MASK_W-1:0]  forward_mask;
        logic [KIND_W-1:0]  dest_kind;
        logic [DPORT_W-1:0] dest_port;
        logic               learned;
    } res_t;

    typedef struct packed {
        logic cmd_pop;
        logic res_push;
    } back_ctl_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EXEC,
        BK_SWEEP
    } bk_state_t;

endpackage

// File: design/lmf_front.sv
// Front end: classifies incoming words and queues them as commands.
// Depends on lmf_pkg.
`timescale 1ns / 1ps

module lmf_front
    import lmf_pkg::*;
#(
    parameter int NUM_PORTS = NUM_PORTS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [FUNC_W-1:0]       func,
    input  logic [ID_W-1:0]         sender_id,
    input  logic [ID_W-1:0]         receiver_id,
    input  logic [PORT_FIELD_W-1:0] port,
    input  logic [ID_W-1:0]         table_device_id,
    input  logic                    push,
    output logic                    full,
    input  logic                    cmd_pop,
    output cmd_t                    cmd_head,
    output logic                    cmd_empty
);

    localparam logic [FUNC_W-1:0] FUNC_PACKET = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_MARK   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_INVAL  = 3'd4;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);
    localparam logic [PORT_FIELD_W:0] PORT_LIMIT = (PORT_FIELD_W + 1)'(NUM_PORTS);
    localparam logic [CNT_W-1:0]      Q_FULL     = CNT_W'(Q_DEPTH);

    cmd_t             cmd_in;
    logic             accept;
    cmd_t             q_mem [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // classify: route ops aimed at the internal port do nothing
    always_comb
    begin
        cmd_in.ext             = {1'b0, port} < PORT_LIMIT;
        cmd_in.port            = port;
        cmd_in.sender_id       = sender_id;
        cmd_in.receiver_id     = receiver_id;
        cmd_in.table_device_id = table_device_id;
        unique case (func)
            FUNC_PACKET: cmd_in.op = OP_PACKET;
            FUNC_SET:    cmd_in.op = cmd_in.ext ? OP_SET : OP_NOP;
            FUNC_MARK:   cmd_in.op = OP_MARK;
            FUNC_CLEAR:  cmd_in.op = OP_CLEAR;
            FUNC_INVAL:  cmd_in.op = cmd_in.ext ? OP_INVAL : OP_NOP;
            default:     cmd_in.op = OP_NOP;
        endcase
    end

    assign full      = (count_reg == Q_FULL);
    assign cmd_empty = (count_reg == '0);
    assign accept    = push && !full;
    assign cmd_head  = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = accept ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(accept) - CNT_W'(cmd_pop);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_mem[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: design/lmf_back.sv
// Back end: route table, lookup/learn sequencer and invalidate sweep.
// Depends on lmf_pkg.
`timescale 1ns / 1ps

module lmf_back
    import lmf_pkg::*;
#(
    parameter int NUM_PORTS   = NUM_PORTS_DEF,
    parameter int NUM_DEVICES = NUM_DEVICES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd_head,
    input  logic              cmd_empty,
    input  logic              res_full,
    input  logic              fwd_en,
    input  logic [MASK_W-1:0] present_mask,
    input  logic [MASK_W-1:0] debug_mask,
    output back_ctl_t         ctl,
    output res_t              res
);

    localparam int ENT_W     = $clog2(NUM_PORTS + 2);
    localparam int DEV_W     = $clog2(NUM_DEVICES);
    localparam int MEM_DEPTH = 1 << DEV_W;
    localparam int CNT_W     = $clog2(NUM_DEVICES + 1);

    localparam logic [ENT_W-1:0] ENT_UNKNOWN  = '0;
    localparam logic [ENT_W-1:0] ENT_INTERNAL = ENT_W'(1);
    localparam logic [ENT_W-1:0] ENT_PORT0    = ENT_W'(2);

    localparam logic [KIND_W-1:0] KIND_UNKNOWN  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EXT      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INTERNAL = 2'd2;

    localparam logic [ID_W:0]         DEV_LIMIT  = (ID_W + 1)'(NUM_DEVICES);
    localparam logic [PORT_FIELD_W:0] MASK_LIMIT = (PORT_FIELD_W + 1)'(MASK_W);
    localparam logic [CNT_W-1:0]      SWEEP_LAST = CNT_W'(NUM_DEVICES);

    bk_state_t        state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    cmd_t             work_reg;

    logic [ENT_W-1:0] table_mem [MEM_DEPTH];
    logic             valid_reg [MEM_DEPTH];
    logic [ENT_W-1:0] rd_a_reg, rd_b_reg;
    logic             rd_a_vld_reg, rd_b_vld_reg;

    logic [DEV_W-1:0] rd_addr_a, rd_addr_b, wr_addr, clr_addr;
    logic [ENT_W-1:0] wr_data;
    logic             wr_en, clr_en;
    logic             start;

    logic [ENT_W-1:0]  sender_ent, receiver_ent, recv_ent, learn_code, dport_full;
    logic [MASK_W-1:0] origin_bit, dest_bit, fwd_mask;
    logic              present, is_debug, sender_in, receiver_in, tdev_in, learn;
    logic [KIND_W-1:0] kind;
    res_t              pkt_res;

    // table storage: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        rd_a_reg     <= table_mem[rd_addr_a];
        rd_b_reg     <= table_mem[rd_addr_b];
        rd_a_vld_reg <= valid_reg[rd_addr_a];
        rd_b_vld_reg <= valid_reg[rd_addr_b];
    end

    // an entry never written reads as unknown
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MEM_DEPTH; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (clr_en)
            begin
                valid_reg[clr_addr] <= 1'b0;
            end
        end
    end

    assign start = (state_reg == BK_IDLE) && !cmd_empty && !res_full;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= cmd_head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (start)
                begin
                    if (cmd_head.op == OP_INVAL)
                    begin
                        state_next = BK_SWEEP;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        state_next = BK_EXEC;
                    end
                end
            end
            BK_EXEC:
            begin
                state_next = BK_IDLE;
            end
            BK_SWEEP:
            begin
                if (cnt_reg == SWEEP_LAST)
                begin
                    state_next = BK_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // forwarding decision from the registered table reads
    always_comb
    begin
        sender_ent   = rd_a_vld_reg ? rd_a_reg : ENT_UNKNOWN;
        receiver_ent = rd_b_vld_reg ? rd_b_reg : ENT_UNKNOWN;
        sender_in    = {1'b0, work_reg.sender_id} < DEV_LIMIT;
        receiver_in  = {1'b0, work_reg.receiver_id} < DEV_LIMIT;
        tdev_in      = {1'b0, work_reg.table_device_id} < DEV_LIMIT;
        learn_code   = ENT_PORT0 + ENT_W'(work_reg.port);

        origin_bit = (work_reg.ext && ({1'b0, work_reg.port} < MASK_LIMIT))
                   ? (MASK_W'(1) << work_reg.port) : '0;
        present    = work_reg.ext ? |(present_mask & origin_bit) : 1'b1;
        is_debug   = |(debug_mask & origin_bit);

        learn = (work_reg.op == OP_PACKET) && work_reg.ext && present && !is_debug
             && (sender_ent != ENT_INTERNAL) && sender_in;

        // a lookup of the sender itself sees the route just learned
        if ((work_reg.receiver_id == BROADCAST_ID) || !receiver_in)
        begin
            recv_ent = ENT_UNKNOWN;
        end
        else if (learn && (work_reg.receiver_id == work_reg.sender_id))
        begin
            recv_ent = learn_code;
        end
        else
        begin
            recv_ent = receiver_ent;
        end

        kind       = KIND_UNKNOWN;
        dport_full = '0;
        if (recv_ent == ENT_INTERNAL)
        begin
            kind = KIND_INTERNAL;
        end
        else if (recv_ent >= ENT_PORT0)
        begin
            kind       = KIND_EXT;
            dport_full = recv_ent - ENT_PORT0;
        end
        dest_bit = MASK_W'(1) << dport_full;

        fwd_mask = '0;
        if (present)
        begin
            fwd_mask = present_mask & debug_mask & ~origin_bit;
            if (fwd_en || !work_reg.ext || (kind == KIND_INTERNAL))
            begin
                if (kind == KIND_UNKNOWN)
                begin
                    fwd_mask = fwd_mask | (present_mask & ~debug_mask & ~origin_bit);
                end
                else if (kind == KIND_EXT)
                begin
                    if ((dest_bit != origin_bit) && |(present_mask & dest_bit))
                    begin
                        fwd_mask = fwd_mask | dest_bit;
                    end
                end
            end
        end

        pkt_res.forward_mask = fwd_mask;
        pkt_res.dest_kind    = kind;
        pkt_res.dest_port    = dport_full[DPORT_W-1:0];
        pkt_res.learned      = learn;
    end

    always_comb
    begin
        ctl.cmd_pop  = start;
        ctl.res_push = 1'b0;
        res          = '0;
        rd_addr_a    = cmd_head.sender_id[DEV_W-1:0];
        rd_addr_b    = cmd_head.receiver_id[DEV_W-1:0];
        wr_en        = 1'b0;
        wr_addr      = work_reg.table_device_id[DEV_W-1:0];
        wr_data      = ENT_UNKNOWN;
        clr_en       = 1'b0;
        clr_addr     = DEV_W'(cnt_reg - CNT_W'(1));
        unique case (state_reg)
            BK_IDLE:
            begin
            end
            BK_EXEC:
            begin
                ctl.res_push = 1'b1;
                unique case (work_reg.op)
                    OP_PACKET:
                    begin
                        res     = pkt_res;
                        wr_en   = learn;
                        wr_addr = work_reg.sender_id[DEV_W-1:0];
                        wr_data = learn_code;
                    end
                    OP_SET:
                    begin
                        wr_en   = tdev_in;
                        wr_data = learn_code;
                    end
                    OP_MARK:
                    begin
                        wr_en   = tdev_in;
                        wr_data = ENT_INTERNAL;
                    end
                    OP_CLEAR:
                    begin
                        wr_en   = tdev_in;
                        wr_data = ENT_UNKNOWN;
                    end
                    default:
                    begin
                    end
                endcase
            end
            BK_SWEEP:
            begin
                // read entry n while checking entry n-1
                rd_addr_a = cnt_reg[DEV_W-1:0];
                clr_en    = (cnt_reg != '0) && rd_a_vld_reg && (rd_a_reg == learn_code);
                if (cnt_reg == SWEEP_LAST)
                begin
                    ctl.res_push = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: design/lmf_res_fifo.sv
// Result queue between the back end and the result ports.
// Depends on lmf_pkg.
`timescale 1ns / 1ps

module lmf_res_fifo
    import lmf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t din,
    output logic full,
    input  logic pop,
    output logic empty,
    output res_t head
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);
    localparam logic [CNT_W-1:0] Q_FULL = CNT_W'(Q_DEPTH);

    res_t             q_mem [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign full   = (count_reg == Q_FULL);
    assign empty  = (count_reg == '0);
    assign do_pop = pop && !empty;
    assign head   = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: design/learning_message_forwarder.sv
// Top level of the learning message forwarder; instantiates lmf_front, lmf_back and
// lmf_res_fifo, uses lmf_pkg and the macros of learning_message_forwarder_assert.svh.
// The block decides where a message goes: it keeps a route table from device id to
// port (unknown, internal or one external port), learns the sender's port from each
// packet that arrives on a present, non-debug port from an in-range sender not marked
// internal, looks up the receiver and returns the port mask, the lookup kind and port,
// and whether a route was learned. Words go in through a queue-like port (push/full)
// and results come out of one (empty/pop), one result per word, in order. A packet,
// set, mark or clear passes the back-end states idle (registered table read) and exec
// (decide and write the table back); the back end takes no new word before it is idle
// again. An invalidate walks the table one entry per cycle through a read port. Each
// word is registered in the input queue before the back end takes it. The table needs
// no clearing pass after reset: each entry has a valid bit that reset clears.
// Registers (APB, 32-bit data): 0x0 forwarding_enable (reset 1), 0x4 port_present_mask,
// 0x8 debug_mirror_mask; write them only while no words are in flight.
`timescale 1ns / 1ps
`include "learning_message_forwarder_assert.svh"

module learning_message_forwarder
    import lmf_pkg::*;
#(
    parameter int NUM_PORTS   = NUM_PORTS_DEF,
    parameter int NUM_DEVICES = NUM_DEVICES_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // input word
    input  logic                    push,
    output logic                    full,
    input  logic [FUNC_W-1:0]       func,
    input  logic [ID_W-1:0]         sender_id,
    input  logic [ID_W-1:0]         receiver_id,
    input  logic [PORT_FIELD_W-1:0] port,
    input  logic [ID_W-1:0]         table_device_id,
    // result word
    output logic                    empty,
    input  logic                    pop,
    output logic [MASK_W-1:0]       forward_mask,
    output logic [KIND_W-1:0]       dest_kind,
    output logic [DPORT_W-1:0]      dest_port,
    output logic                    learned,
    // configuration
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [3:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam logic [1:0] REG_FWD_EN  = 2'd0;
    localparam logic [1:0] REG_PRESENT = 2'd1;
    localparam logic [1:0] REG_DEBUG   = 2'd2;

    logic              fwd_en_reg, fwd_en_next;
    logic [MASK_W-1:0] present_reg, present_next;
    logic [MASK_W-1:0] debug_reg, debug_next;
    logic              cfg_wr;
    logic [1:0]        reg_idx;

    cmd_t      cmd_head;
    logic      cmd_empty;
    logic      res_full;
    back_ctl_t bk_ctl;
    res_t      bk_res;
    res_t      out_head;

    // config port: zero-wait APB, word-aligned registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_comb
    begin
        fwd_en_next  = fwd_en_reg;
        present_next = present_reg;
        debug_next   = debug_reg;
        if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_FWD_EN:  fwd_en_next  = pwdata[0];
                REG_PRESENT: present_next = pwdata[MASK_W-1:0];
                REG_DEBUG:   debug_next   = pwdata[MASK_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_FWD_EN:  prdata = 32'(fwd_en_reg);
            REG_PRESENT: prdata = 32'(present_reg);
            REG_DEBUG:   prdata = 32'(debug_reg);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_en_reg  <= 1'b1;
            present_reg <= '0;
            debug_reg   <= '0;
        end
        else
        begin
            fwd_en_reg  <= fwd_en_next;
            present_reg <= present_next;
            debug_reg   <= debug_next;
        end
    end

    // classify and queue incoming words
    lmf_front #(
        .NUM_PORTS (NUM_PORTS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .func            (func),
        .sender_id       (sender_id),
        .receiver_id     (receiver_id),
        .port            (port),
        .table_device_id (table_device_id),
        .push            (push),
        .full            (full),
        .cmd_pop         (bk_ctl.cmd_pop),
        .cmd_head        (cmd_head),
        .cmd_empty       (cmd_empty)
    );

    // look up, learn and sweep the route table
    lmf_back #(
        .NUM_PORTS   (NUM_PORTS),
        .NUM_DEVICES (NUM_DEVICES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_head     (cmd_head),
        .cmd_empty    (cmd_empty),
        .res_full     (res_full),
        .fwd_en       (fwd_en_reg),
        .present_mask (present_reg),
        .debug_mask   (debug_reg),
        .ctl          (bk_ctl),
        .res          (bk_res)
    );

    // hold finished results until popped
    lmf_res_fifo u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (bk_ctl.res_push),
        .din   (bk_res),
        .full  (res_full),
        .pop   (pop),
        .empty (empty),
        .head  (out_head)
    );

    assign forward_mask = out_head.forward_mask;
    assign dest_kind    = out_head.dest_kind;
    assign dest_port    = out_head.dest_port;
    assign learned      = out_head.learned;

    // a result is never pushed into a full queue
    `LMF_ASSERT_IMP(a_res_no_overflow, bk_ctl.res_push, !res_full, "result pushed into full queue")
    // an accepted word is queued for the back end on the next cycle
    `LMF_ASSERT_NXT(a_cmd_queued, push && !full, !cmd_empty, "accepted word not queued")
    // the back end starts a command only when one waits and a result slot is free
    `LMF_ASSERT_IMP(a_start_ok, bk_ctl.cmd_pop, !cmd_empty && !res_full, "command started without room")

endmodule
